### rtl/core/pec_pkg.sv
// Package: constants, types and codes shared by the page extent coalescer.
`timescale 1ns / 1ps
package pec_pkg;

    localparam int EXTENTS         = 64;
    localparam int PHYS_FRAME_BITS = 40;
    localparam int VIRT_PAGE_BITS  = 36;
    localparam int SLOT_BITS       = $clog2(EXTENTS);
    localparam int CNT_BITS        = 32;
    localparam int ID_BITS         = 64;
    localparam int STATUS_BITS     = 3;

    // Input word: phys_frame, virt_page
    localparam int IN_BITS  = PHYS_FRAME_BITS + VIRT_PAGE_BITS;
    localparam int IN_DATA  = ((IN_BITS + 7) / 8) * 8;
    // Output word: status, extent_tag, start_frame, start_virt, page_count, pages_seen
    localparam int OUT_BITS = STATUS_BITS + ID_BITS + PHYS_FRAME_BITS + VIRT_PAGE_BITS
                              + 2 * CNT_BITS;
    localparam int OUT_DATA = ((OUT_BITS + 7) / 8) * 8;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [PHYS_FRAME_BITS-1:0] start_frame;
        logic [PHYS_FRAME_BITS-1:0] end_frame;
        logic [VIRT_PAGE_BITS-1:0]  start_virt;
        logic [VIRT_PAGE_BITS-1:0]  end_virt;
        logic [CNT_BITS-1:0]        pages;
        logic [ID_BITS-1:0]         id;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [STATUS_BITS-1:0] {
        ST_NEW     = 3'd0,
        ST_APPEND  = 3'd1,
        ST_PREPEND = 3'd2,
        ST_JOIN    = 3'd3,
        ST_DUP     = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RDLO,
        S_RDHI,
        S_DECIDE,
        S_WRITE,
        S_OUT
    } state_t;

endpackage

### rtl/core/pec_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module pec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/page_extent_coalescer.sv
// Top level: page extent coalescer, extent table in RAM scanned per word.
//
//  channel | dir | tdata (low bit first)
//  s_axis  | in  | phys_frame, virt_page
//  m_axis  | out | status, extent_tag, start_frame, start_virt, page_count, pages_seen
//
// Per item: one RAM read per entry during the scan plus a drain at its end, two reads
// for the chosen neighbors, a decide step, then one write; a join only drops the upper
// valid bit.
// Reset clears the valid bits and counters; the table RAM needs no clearing.
// A result waits in the output register; the next word is taken when it is taken.
`timescale 1ns / 1ps
module page_extent_coalescer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // phys_frame [39:0], virt_page [75:40]
    input  logic [pec_pkg::IN_DATA-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status [2:0], extent_tag [66:3], start_frame [106:67], start_virt [142:107],
    // page_count [174:143], pages_seen [206:175]
    output logic [pec_pkg::OUT_DATA-1:0]   m_axis_tdata
);
    import pec_pkg::*;

    localparam logic [SLOT_BITS:0] SCAN_END = (SLOT_BITS+1)'(EXTENTS);

    state_t state_reg, state_next;

    logic [EXTENTS-1:0]         valid_reg;
    logic [PHYS_FRAME_BITS-1:0] frame_reg;
    logic [VIRT_PAGE_BITS-1:0]  virt_reg;
    logic [SLOT_BITS:0]         addr_reg;      // scan read address
    logic                       rd_pend_reg;   // data for addr_reg-1 arriving
    logic [SLOT_BITS-1:0]       rd_slot_reg;
    logic                       lo_ok_reg, hi_ok_reg, dup_ok_reg, free_ok_reg;
    logic [SLOT_BITS-1:0]       lo_reg, hi_reg, dup_reg, free_reg;
    logic [PHYS_FRAME_BITS-1:0] lo_start_reg, hi_start_reg;
    entry_t                     lo_e_reg, hi_e_reg;
    logic [ID_BITS-1:0]         next_id_reg;
    logic [CNT_BITS-1:0]        total_reg;
    logic [OUT_DATA-1:0]        out_reg;
    logic                       out_valid_reg;

    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
    entry_t               ram_wdata, ram_rdata;

    pec_ram #(.WIDTH(ENTRY_BITS), .DEPTH(EXTENTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decision on the registered neighbors
    logic                 up_adj, lo_adj;
    status_t              st;
    entry_t               res_e;
    logic [SLOT_BITS-1:0] res_slot;
    logic [CNT_BITS:0]    sum_w;
    logic [CNT_BITS-1:0]  lo_p1, hi_p1, join_cnt;

    always_comb
    begin
        up_adj = hi_ok_reg && (frame_reg + 1'b1 == hi_e_reg.start_frame)
                 && (virt_reg + 1'b1 == hi_e_reg.start_virt);
        lo_adj = lo_ok_reg && (lo_e_reg.end_frame + 1'b1 == frame_reg)
                 && (lo_e_reg.end_virt + 1'b1 == virt_reg);
        lo_p1 = (&lo_e_reg.pages) ? lo_e_reg.pages : lo_e_reg.pages + 1'b1;
        hi_p1 = (&hi_e_reg.pages) ? hi_e_reg.pages : hi_e_reg.pages + 1'b1;
        sum_w = {1'b0, lo_p1} + {1'b0, hi_e_reg.pages};
        join_cnt = sum_w[CNT_BITS] ? '1 : sum_w[CNT_BITS-1:0];
        res_e = lo_e_reg;
        res_slot = lo_reg;
        if (dup_ok_reg)
        begin
            st = ST_DUP;
            res_e = lo_e_reg;
            res_slot = dup_reg;
        end
        else if (lo_adj && up_adj)
        begin
            st = ST_JOIN;
            res_e.end_frame = hi_e_reg.end_frame;
            res_e.end_virt  = hi_e_reg.end_virt;
            res_e.pages     = join_cnt;
        end
        else if (lo_adj)
        begin
            st = ST_APPEND;
            res_e.end_frame = frame_reg;
            res_e.end_virt  = virt_reg;
            res_e.pages     = lo_p1;
        end
        else if (up_adj)
        begin
            st = ST_PREPEND;
            res_e = hi_e_reg;
            res_e.start_frame = frame_reg;
            res_e.start_virt  = virt_reg;
            res_e.pages       = hi_p1;
            res_slot = hi_reg;
        end
        else if (free_ok_reg)
        begin
            st = ST_NEW;
            res_e.start_frame = frame_reg;
            res_e.end_frame   = frame_reg;
            res_e.start_virt  = virt_reg;
            res_e.end_virt    = virt_reg;
            res_e.pages       = CNT_BITS'(1);
            res_e.id          = next_id_reg + 1'b1;
            res_slot = free_reg;
        end
        else
        begin
            st = ST_FULL;
            res_e = '0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_axis_tvalid && s_axis_tready) state_next = S_SCAN;
            S_SCAN:   if (addr_reg == SCAN_END && !rd_pend_reg) state_next = S_RDLO;
            S_RDLO:   state_next = S_RDHI;
            S_RDHI:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_WRITE;
            S_WRITE:  state_next = S_OUT;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs and RAM control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = res_slot;
        ram_wdata = res_e;
        ram_raddr = addr_reg[SLOT_BITS-1:0];
        case (state_reg)
            S_SCAN:   ram_raddr = (dup_ok_reg ? dup_reg : lo_reg);
            S_RDLO:   ram_raddr = hi_reg;
            S_WRITE:  ram_we = (st != ST_DUP) && (st != ST_FULL);
            default:  ram_raddr = addr_reg[SLOT_BITS-1:0];
        endcase
        if (state_reg == S_SCAN && addr_reg != SCAN_END)
        begin
            ram_raddr = addr_reg[SLOT_BITS-1:0];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            next_id_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        addr_reg    <= '0;
                        rd_pend_reg <= 1'b0;
                        total_reg   <= total_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    // Issue one read per cycle, compare the word returned
                    if (addr_reg != SCAN_END)
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                    rd_pend_reg <= (addr_reg != SCAN_END);
                end
                S_WRITE:
                begin
                    if (st == ST_NEW)
                    begin
                        valid_reg[free_reg] <= 1'b1;
                        next_id_reg <= next_id_reg + 1'b1;
                    end
                    if (st == ST_JOIN)
                    begin
                        valid_reg[hi_reg] <= 1'b0;
                    end
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Scan compare, neighbor capture and result word
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                frame_reg   <= s_axis_tdata[PHYS_FRAME_BITS-1:0];
                virt_reg    <= s_axis_tdata[IN_BITS-1:PHYS_FRAME_BITS];
                lo_ok_reg   <= 1'b0;
                hi_ok_reg   <= 1'b0;
                dup_ok_reg  <= 1'b0;
                free_ok_reg <= 1'b0;
                lo_reg      <= '0;
                hi_reg      <= '0;
                dup_reg     <= '0;
                free_reg    <= '0;
            end
            S_SCAN:
            begin
                rd_slot_reg <= addr_reg[SLOT_BITS-1:0];
                if (rd_pend_reg)
                begin
                    if (!valid_reg[rd_slot_reg])
                    begin
                        if (!free_ok_reg)
                        begin
                            free_ok_reg <= 1'b1;
                            free_reg    <= rd_slot_reg;
                        end
                    end
                    else if (ram_rdata.start_frame == frame_reg)
                    begin
                        dup_ok_reg <= 1'b1;
                        dup_reg    <= rd_slot_reg;
                    end
                    else if (ram_rdata.start_frame < frame_reg)
                    begin
                        if (!lo_ok_reg || ram_rdata.start_frame > lo_start_reg)
                        begin
                            lo_ok_reg    <= 1'b1;
                            lo_reg       <= rd_slot_reg;
                            lo_start_reg <= ram_rdata.start_frame;
                        end
                    end
                    else
                    begin
                        if (!hi_ok_reg || ram_rdata.start_frame < hi_start_reg)
                        begin
                            hi_ok_reg    <= 1'b1;
                            hi_reg       <= rd_slot_reg;
                            hi_start_reg <= ram_rdata.start_frame;
                        end
                    end
                end
            end
            S_RDLO:   lo_e_reg <= ram_rdata;
            S_RDHI:   hi_e_reg <= ram_rdata;
            S_WRITE:
            begin
                out_reg <= OUT_DATA'({total_reg, res_e.pages, res_e.start_virt,
                                      res_e.start_frame, res_e.id, st});
            end
            default:
            begin
            end
        endcase
    end

    // A word is only taken with no result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while result pending");
    // A result appears only after a write step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == S_WRITE)
        else $error("result without a finished item");
    // A join always frees the upper slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && st == ST_JOIN) |=> !valid_reg[$past(hi_reg)])
        else $error("join left upper slot valid");

endmodule

### tb/testbench.sv
// Testbench for the page extent coalescer: directed table and random page maps.
`timescale 1ns / 1ps
module testbench;
    import pec_pkg::*;

    localparam int LAT_CYCLES  = EXTENTS + 16;
    localparam int STALL_LIMIT = 20000;
    localparam logic [PHYS_FRAME_BITS-1:0] PMAX = {PHYS_FRAME_BITS{1'b1}};
    localparam logic [VIRT_PAGE_BITS-1:0]  VMAX = {VIRT_PAGE_BITS{1'b1}};

    typedef struct packed {
        status_t                    status;
        logic [ID_BITS-1:0]         extent_tag;
        logic [PHYS_FRAME_BITS-1:0] start_frame;
        logic [VIRT_PAGE_BITS-1:0]  start_virt;
        logic [CNT_BITS-1:0]        page_count;
        logic [CNT_BITS-1:0]        pages_seen;
    } extent_word_t;

    typedef struct {
        logic [PHYS_FRAME_BITS-1:0] frame;
        logic [VIRT_PAGE_BITS-1:0]  virt;
        bit                         typed;
        extent_word_t               want;
    } map_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA-1:0]   s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_DATA-1:0]  m_axis_tdata;

    page_extent_coalescer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow extent table
    bit                         tbl_valid [EXTENTS];
    logic [PHYS_FRAME_BITS-1:0] tbl_sf    [EXTENTS];
    logic [PHYS_FRAME_BITS-1:0] tbl_ef    [EXTENTS];
    logic [VIRT_PAGE_BITS-1:0]  tbl_sv    [EXTENTS];
    logic [VIRT_PAGE_BITS-1:0]  tbl_ev    [EXTENTS];
    logic [CNT_BITS-1:0]        tbl_pages [EXTENTS];
    logic [ID_BITS-1:0]         tbl_id    [EXTENTS];
    logic [ID_BITS-1:0]         last_id;
    logic [CNT_BITS-1:0]        seen_total;

    extent_word_t pending_extents [$];

    int  errors;
    int  idle_pct;
    int  quiet_cycles;
    bit  hold_sender;

    function automatic logic [CNT_BITS-1:0] sat_sum(logic [CNT_BITS-1:0] a,
                                                    logic [CNT_BITS-1:0] b);
        logic [CNT_BITS:0] s;
        s = a + b;
        return s[CNT_BITS] ? {CNT_BITS{1'b1}} : s[CNT_BITS-1:0];
    endfunction

    function automatic extent_word_t describe(status_t st, int slot);
        extent_word_t w;
        w = '0;
        w.status = st;
        if (slot >= 0)
        begin
            w.extent_tag  = tbl_id[slot];
            w.start_frame = tbl_sf[slot];
            w.start_virt  = tbl_sv[slot];
            w.page_count  = tbl_pages[slot];
        end
        w.pages_seen = seen_total;
        return w;
    endfunction

    // Predict the result of mapping one page and update the shadow table
    function automatic extent_word_t coalesce_page(logic [PHYS_FRAME_BITS-1:0] frame,
                                                   logic [VIRT_PAGE_BITS-1:0] virt);
        int  lo, hi, dup, free_slot;
        bit  up_adj;
        lo = -1; hi = -1; dup = -1; free_slot = -1;
        seen_total = seen_total + 1;
        for (int i = 0; i < EXTENTS; i++)
        begin
            if (!tbl_valid[i])
            begin
                if (free_slot < 0) free_slot = i;
            end
            else if (tbl_sf[i] == frame)
                dup = i;
            else if (tbl_sf[i] < frame)
            begin
                if (lo < 0 || tbl_sf[i] > tbl_sf[lo]) lo = i;
            end
            else if (hi < 0 || tbl_sf[i] < tbl_sf[hi])
                hi = i;
        end
        if (dup >= 0) return describe(ST_DUP, dup);
        up_adj = hi >= 0 && (frame + 1'b1) == tbl_sf[hi] && (virt + 1'b1) == tbl_sv[hi];
        if (lo >= 0 && (tbl_ef[lo] + 1'b1) == frame && (tbl_ev[lo] + 1'b1) == virt)
        begin
            tbl_ef[lo] = frame;
            tbl_ev[lo] = virt;
            tbl_pages[lo] = sat_sum(tbl_pages[lo], 1);
            if (up_adj)
            begin
                tbl_ef[lo] = tbl_ef[hi];
                tbl_ev[lo] = tbl_ev[hi];
                tbl_pages[lo] = sat_sum(tbl_pages[lo], tbl_pages[hi]);
                tbl_valid[hi] = 0;
                return describe(ST_JOIN, lo);
            end
            return describe(ST_APPEND, lo);
        end
        if (up_adj)
        begin
            tbl_sf[hi] = frame;
            tbl_sv[hi] = virt;
            tbl_pages[hi] = sat_sum(tbl_pages[hi], 1);
            return describe(ST_PREPEND, hi);
        end
        if (free_slot < 0) return describe(ST_FULL, -1);
        last_id = last_id + 1;
        tbl_valid[free_slot] = 1;
        tbl_sf[free_slot] = frame;
        tbl_ef[free_slot] = frame;
        tbl_sv[free_slot] = virt;
        tbl_ev[free_slot] = virt;
        tbl_pages[free_slot] = 1;
        tbl_id[free_slot] = last_id;
        return describe(ST_NEW, free_slot);
    endfunction

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Send one page word and record its expected extent; valid stays up after the accept
    task automatic map_page(logic [PHYS_FRAME_BITS-1:0] frame,
                            logic [VIRT_PAGE_BITS-1:0] virt,
                            bit typed, extent_word_t want);
        extent_word_t pred;
        while (($urandom_range(99) < idle_pct) || hold_sender)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA'({virt, frame});
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pred = coalesce_page(frame, virt);
        if (typed && pred != want)
        begin
            $display("%0t typed row disagrees with predictor: exp %h act %h",
                     $time, want, pred);
            errors++;
        end
        pending_extents.push_back(typed ? want : pred);
    endtask

    // Receiver: random stalls, field-by-field compare
    always @(posedge clk)
    begin
        extent_word_t got, exp;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[2:0], m_axis_tdata[66:3], m_axis_tdata[106:67],
                       m_axis_tdata[142:107], m_axis_tdata[174:143], m_axis_tdata[206:175]};
                if (pending_extents.size() == 0)
                begin
                    $display("%0t unexpected extent word: act %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp = pending_extents.pop_front();
                    if (got.status != exp.status)
                    begin
                        $display("%0t status exp %0d act %0d", $time, exp.status, got.status);
                        errors++;
                    end
                    if (got.extent_tag != exp.extent_tag)
                    begin
                        $display("%0t extent_tag exp %h act %h", $time,
                                 exp.extent_tag, got.extent_tag);
                        errors++;
                    end
                    if (got.start_frame != exp.start_frame)
                    begin
                        $display("%0t start_frame exp %h act %h", $time,
                                 exp.start_frame, got.start_frame);
                        errors++;
                    end
                    if (got.start_virt != exp.start_virt)
                    begin
                        $display("%0t start_virt exp %h act %h", $time,
                                 exp.start_virt, got.start_virt);
                        errors++;
                    end
                    if (got.page_count != exp.page_count)
                    begin
                        $display("%0t page_count exp %h act %h", $time,
                                 exp.page_count, got.page_count);
                        errors++;
                    end
                    if (got.pages_seen != exp.pages_seen)
                    begin
                        $display("%0t pages_seen exp %h act %h", $time,
                                 exp.pages_seen, got.pages_seen);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
        else
        begin
            m_axis_tready <= 1'b0;
        end
    end

    // Watchdog: cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("page_extent_coalescer verification failed");
            $finish;
        end
    end

    function automatic extent_word_t word_of(status_t st, logic [ID_BITS-1:0] id,
                                             logic [PHYS_FRAME_BITS-1:0] f,
                                             logic [VIRT_PAGE_BITS-1:0] v,
                                             logic [CNT_BITS-1:0] n,
                                             logic [CNT_BITS-1:0] seen);
        return '{st, id, f, v, n, seen};
    endfunction

    initial
    begin
        map_row_t rows [$];
        logic [PHYS_FRAME_BITS-1:0] f, base;
        logic [VIRT_PAGE_BITS-1:0]  v;
        int run, k, wait_cycles;
        idle_pct = 23; hold_sender = 0;
        for (int i = 0; i < EXTENTS; i++) tbl_valid[i] = 0;
        last_id = 0; seen_total = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, append, prepend, join, duplicate, inside, wrap
        rows.push_back('{'0, '0, 1, word_of(ST_NEW, 1, 0, 0, 1, 1)});
        rows.push_back('{'0, VMAX, 1, word_of(ST_DUP, 1, 0, 0, 1, 2)});
        rows.push_back('{1, 1, 1, word_of(ST_APPEND, 1, 0, 0, 2, 3)});
        rows.push_back('{PMAX, VMAX, 1, word_of(ST_NEW, 2, PMAX, VMAX, 1, 4)});
        rows.push_back('{40'h10, 36'h20, 0, '0});
        rows.push_back('{40'h12, 36'h22, 0, '0});
        rows.push_back('{40'h11, 36'h21, 0, '0});
        rows.push_back('{40'h0f, 36'h1f, 0, '0});
        rows.push_back('{40'h11, 36'h21, 0, '0});
        rows.push_back('{40'h30, 36'h5, 0, '0});
        rows.push_back('{40'h31, 36'h9, 0, '0});
        rows.push_back('{PMAX - 1, VMAX - 1, 0, '0});
        rows.push_back('{40'h5555555555, 36'haaaaaaaaa, 0, '0});
        rows.push_back('{40'haaaaaaaaaa, 36'h555555555, 0, '0});
        foreach (rows[i]) map_page(rows[i].frame, rows[i].virt, rows[i].typed, rows[i].want);
        s_axis_tvalid <= 1'b0;

        // Pause until the table has drained all results
        hold_sender = 1;
        while (pending_extents.size() != 0) @(posedge clk);
        hold_sender = 0;

        // Random: runs of contiguous pages, noise, and a table-full phase
        k = 0;
        while (k < 500)
        begin
            if (k > 150 && k < 260) idle_pct = 0;
            else idle_pct = 23;
            if (k > 300 && k < 420)
                base = PHYS_FRAME_BITS'({$urandom, $urandom});
            else
                base = PHYS_FRAME_BITS'($urandom_range(255));
            v = VIRT_PAGE_BITS'({$urandom, $urandom});
            run = $urandom_range(1, 6);
            case ($urandom_range(9))
                0: for (int j = 0; j < run; j++)
                   begin
                       map_page(base - j, v - j, 0, '0); k++;
                   end
                1: begin
                       map_page(PHYS_FRAME_BITS'({$urandom, $urandom}),
                                VIRT_PAGE_BITS'({$urandom, $urandom}), 0, '0); k++;
                   end
                2: begin
                       map_page(base + 2, v + 2, 0, '0);
                       map_page(base, v, 0, '0);
                       map_page(base + 1, v + 1, 0, '0); k += 3;
                   end
                default: for (int j = 0; j < run; j++)
                   begin
                       f = base + j;
                       map_page(f, ($urandom_range(7) == 0) ? v : v + j, 0, '0); k++;
                   end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_extents.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LAT_CYCLES) @(posedge clk);
        if (errors == 0 && pending_extents.size() == 0)
            $display("page_extent_coalescer verification clean");
        else
            $display("page_extent_coalescer verification failed");
        $finish;
    end
endmodule

### filelist.f
rtl/core/pec_pkg.sv
rtl/core/pec_ram.sv
rtl/core/page_extent_coalescer.sv
tb/testbench.sv
